/* rtl/pbrc_pkg.sv */
// Shared types and constants for the packet block rule check.
// Holds the input and result word layouts and the store geometry.
// No dependencies.
`timescale 1ns / 1ps

package pbrc_pkg;

    // Store geometry.
    localparam int IP_ENTRIES    = 64;
    localparam int IP_AW         = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
    localparam int APP_TYPES     = 32;
    localparam int APP_AW        = (APP_TYPES > 1) ? $clog2(APP_TYPES) : 1;
    localparam int PORT_W        = 16;
    localparam int PORT_ROW_BITS = 64;
    localparam int PORT_SEL_W    = $clog2(PORT_ROW_BITS);
    localparam int PORT_ROW_AW   = PORT_W - PORT_SEL_W;
    localparam int PORT_ROWS     = (1 << PORT_W) / PORT_ROW_BITS;

    // Item kinds.
    typedef enum logic [2:0] {
        KIND_CHECK        = 3'd0,
        KIND_BLOCK_IP     = 3'd1,
        KIND_UNBLOCK_IP   = 3'd2,
        KIND_BLOCK_PORT   = 3'd3,
        KIND_UNBLOCK_PORT = 3'd4,
        KIND_BLOCK_APP    = 3'd5,
        KIND_UNBLOCK_APP  = 3'd6,
        KIND_CLEAR_ALL    = 3'd7
    } t_kind;

    // Which rule set matched a check.
    typedef enum logic [1:0] {
        REASON_NONE = 2'd0,
        REASON_IP   = 2'd1,
        REASON_PORT = 2'd2,
        REASON_APP  = 2'd3
    } t_reason;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ip_addr;
        logic [15:0] port_number;
        logic [4:0]  app_id;
    } t_in_word;

    typedef struct packed {
        logic    blocked;
        t_reason reason;
        logic    table_full;
    } t_out_word;

endpackage

/* rtl/packet_block_rule_check.sv */
// Packet block rule check: IP table, port bitmap and app bitmap with one result per word.
// Depends on pbrc_pkg for word layouts, kind and reason codes and store sizes.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake                    | Word
//  ---------+-----------+------------------------------+---------------------
//  in       | input     | i_in_valid / o_in_stall      | i_in_word  (t_in_word)
//  out      | output    | o_out_valid / i_out_stall    | o_out_word (t_out_word)
//
// A check, block ip or unblock ip word walks the IP table memory one entry per cycle
// through its single read port. Port rule words do one read-modify-write of a port
// bitmap row; app rule words update the app bitmap as they are accepted.
// Clear all wipes the port bitmap one row per cycle; after reset the same clearing pass
// runs before the first word is accepted.
// A finished result sits in the output register, so a stalled output does not hold
// the next input word back; only a new result waits for that register to empty.

module packet_block_rule_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pbrc_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pbrc_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_CLEAR  = 4'b1000
    } t_state;

    localparam logic [pbrc_pkg::IP_AW-1:0] IP_LAST =
        pbrc_pkg::IP_AW'(pbrc_pkg::IP_ENTRIES - 1);
    localparam logic [pbrc_pkg::PORT_ROW_AW-1:0] ROW_LAST =
        pbrc_pkg::PORT_ROW_AW'(pbrc_pkg::PORT_ROWS - 1);

    // Control state.
    t_state                              r_state, n_state;
    logic [pbrc_pkg::IP_AW-1:0]          r_idx, n_idx;
    logic                                r_hit, n_hit;
    logic                                r_free_found, n_free_found;
    logic [pbrc_pkg::IP_AW-1:0]          r_free_idx, n_free_idx;
    logic [pbrc_pkg::PORT_ROW_AW-1:0]    r_clr_row, n_clr_row;
    logic                                r_emit, n_emit;
    logic [pbrc_pkg::IP_ENTRIES-1:0]     r_ip_valid, n_ip_valid;
    logic [pbrc_pkg::APP_TYPES-1:0]      r_app_map, n_app_map;
    logic                                r_out_valid, n_out_valid;

    // Payload registers.
    pbrc_pkg::t_in_word                  r_item;
    pbrc_pkg::t_out_word                 r_out_word, n_out_word;

    // Memories and their registered read data.
    logic [31:0]                         r_ip_mem [pbrc_pkg::IP_ENTRIES];
    logic [31:0]                         r_ip_q;
    logic [pbrc_pkg::PORT_ROW_BITS-1:0]  r_port_mem [pbrc_pkg::PORT_ROWS];
    logic [pbrc_pkg::PORT_ROW_BITS-1:0]  r_port_q;

    // Memory access controls.
    logic                                ip_rd_en;
    logic [pbrc_pkg::IP_AW-1:0]          ip_rd_addr;
    logic                                ip_we;
    logic [pbrc_pkg::IP_AW-1:0]          ip_wr_addr;
    logic                                port_rd_en;
    logic [pbrc_pkg::PORT_ROW_AW-1:0]    port_rd_addr;
    logic                                port_we;
    logic [pbrc_pkg::PORT_ROW_AW-1:0]    port_wr_addr;
    logic [pbrc_pkg::PORT_ROW_BITS-1:0]  port_wr_data;

    logic                                in_accept;
    logic                                out_free;
    logic                                in_app_ok;
    logic                                item_app_ok;
    logic                                entry_match;
    logic [pbrc_pkg::PORT_SEL_W-1:0]     item_bit;
    logic [pbrc_pkg::PORT_ROW_AW-1:0]    item_row;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_app_ok   = int'(i_in_word.app_id) < pbrc_pkg::APP_TYPES;
    assign item_app_ok = int'(r_item.app_id) < pbrc_pkg::APP_TYPES;
    assign item_bit    = r_item.port_number[pbrc_pkg::PORT_SEL_W-1:0];
    assign item_row    = r_item.port_number[pbrc_pkg::PORT_W-1:pbrc_pkg::PORT_SEL_W];
    assign entry_match = r_ip_valid[r_idx] && (r_ip_q == r_item.ip_addr);
    assign ip_wr_addr  = r_free_idx;

    // Sequencer: take a word, walk the IP table, update or clear port rows, post the result.
    always_comb begin
        pbrc_pkg::t_out_word res;

        n_state      = r_state;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_clr_row    = r_clr_row;
        n_emit       = r_emit;
        n_ip_valid   = r_ip_valid;
        n_app_map    = r_app_map;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        ip_rd_en     = 1'b0;
        ip_rd_addr   = r_idx + 1'b1;
        ip_we        = 1'b0;
        port_rd_en   = 1'b0;
        port_rd_addr = i_in_word.port_number[pbrc_pkg::PORT_W-1:pbrc_pkg::PORT_SEL_W];
        port_we      = 1'b0;
        port_wr_addr = item_row;
        port_wr_data = r_port_q;
        res          = '0;

        unique case (r_state)
            S_CLEAR: begin
                port_we      = 1'b1;
                port_wr_addr = r_clr_row;
                port_wr_data = '0;
                n_clr_row    = r_clr_row + 1'b1;
                if (r_clr_row == ROW_LAST) begin
                    n_state = r_emit ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    port_rd_en   = 1'b1;
                    ip_rd_en     = 1'b1;
                    ip_rd_addr   = '0;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_free_idx   = '0;
                    n_emit       = 1'b0;
                    unique case (i_in_word.kind)
                        pbrc_pkg::KIND_CHECK,
                        pbrc_pkg::KIND_BLOCK_IP,
                        pbrc_pkg::KIND_UNBLOCK_IP: begin
                            n_state = S_SCAN;
                        end
                        pbrc_pkg::KIND_BLOCK_PORT,
                        pbrc_pkg::KIND_UNBLOCK_PORT: begin
                            n_state = S_FINISH;
                        end
                        pbrc_pkg::KIND_BLOCK_APP: begin
                            if (in_app_ok) begin
                                n_app_map[i_in_word.app_id[pbrc_pkg::APP_AW-1:0]] = 1'b1;
                            end
                            n_state = S_FINISH;
                        end
                        pbrc_pkg::KIND_UNBLOCK_APP: begin
                            if (in_app_ok) begin
                                n_app_map[i_in_word.app_id[pbrc_pkg::APP_AW-1:0]] = 1'b0;
                            end
                            n_state = S_FINISH;
                        end
                        pbrc_pkg::KIND_CLEAR_ALL: begin
                            n_ip_valid = '0;
                            n_app_map  = '0;
                            n_clr_row  = '0;
                            n_emit     = 1'b1;
                            n_state    = S_CLEAR;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // One table entry per cycle; the next entry is read while this one compares.
                if (entry_match) begin
                    n_hit = 1'b1;
                    if (r_item.kind == pbrc_pkg::KIND_UNBLOCK_IP) begin
                        n_ip_valid[r_idx] = 1'b0;
                    end
                end
                if (!r_ip_valid[r_idx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IP_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    ip_rd_en = 1'b1;
                end
            end
            S_FINISH: begin
                // Build the result in rule order: IP, then port, then app.
                if (r_item.kind == pbrc_pkg::KIND_CHECK) begin
                    priority if (r_hit) begin
                        res.blocked = 1'b1;
                        res.reason  = pbrc_pkg::REASON_IP;
                    end else if (r_port_q[item_bit]) begin
                        res.blocked = 1'b1;
                        res.reason  = pbrc_pkg::REASON_PORT;
                    end else if (item_app_ok &&
                                 r_app_map[r_item.app_id[pbrc_pkg::APP_AW-1:0]]) begin
                        res.blocked = 1'b1;
                        res.reason  = pbrc_pkg::REASON_APP;
                    end
                end
                if (r_item.kind == pbrc_pkg::KIND_BLOCK_IP && !r_hit && !r_free_found) begin
                    res.table_full = 1'b1;
                end
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = res;
                    n_state     = S_IDLE;
                    // Port rule updates and IP inserts commit once, together with the result.
                    if (r_item.kind == pbrc_pkg::KIND_BLOCK_PORT) begin
                        port_we                = 1'b1;
                        port_wr_data[item_bit] = 1'b1;
                    end
                    if (r_item.kind == pbrc_pkg::KIND_UNBLOCK_PORT) begin
                        port_we                = 1'b1;
                        port_wr_data[item_bit] = 1'b0;
                    end
                    if (r_item.kind == pbrc_pkg::KIND_BLOCK_IP && !r_hit && r_free_found) begin
                        ip_we                  = 1'b1;
                        n_ip_valid[r_free_idx] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the port bitmap clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_clr_row    <= '0;
            r_emit       <= 1'b0;
            r_ip_valid   <= '0;
            r_app_map    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_clr_row    <= n_clr_row;
            r_emit       <= n_emit;
            r_ip_valid   <= n_ip_valid;
            r_app_map    <= n_app_map;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    // IP address table memory.
    always_ff @(posedge i_clk) begin
        if (ip_we) begin
            r_ip_mem[ip_wr_addr] <= r_item.ip_addr;
        end
        if (ip_rd_en) begin
            r_ip_q <= r_ip_mem[ip_rd_addr];
        end
    end

    // Port bitmap memory, one row of bits per address.
    always_ff @(posedge i_clk) begin
        if (port_we) begin
            r_port_mem[port_wr_addr] <= port_wr_data;
        end
        if (port_rd_en) begin
            r_port_q <= r_port_mem[port_rd_addr];
        end
    end

`ifndef SYNTHESIS
    // A result reports blocked exactly when it names a reason.
    a_reason_matches_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.blocked == (r_out_word.reason != pbrc_pkg::REASON_NONE)))
        else $error("blocked flag and reason disagree");

    // Clear all drops every IP table entry at once.
    a_clear_drops_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.kind == pbrc_pkg::KIND_CLEAR_ALL) |=> (r_ip_valid == '0))
        else $error("IP entries still valid after clear all");

    // An insert only lands in an entry that is free.
    a_insert_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ip_we |-> !r_ip_valid[ip_wr_addr])
        else $error("IP insert overwrites a valid entry");

    // A finished result waits while the output register is still held.
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !out_free) |=> (r_state == S_FINISH))
        else $error("result left while output register was busy");

    // A table walk always starts at the first entry.
    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && in_accept && n_state == S_SCAN) |=> (r_idx == '0))
        else $error("table walk did not start at entry zero");
`endif

endmodule
